### sv/ipls_pkg.sv
// Package for the IR pulse-length packet sender.
// Holds the request and result struct types, request kind codes and packet constants.
// No dependencies.
`default_nettype none

package ipls_pkg;

	// Packet store geometry
	localparam int STORE_BYTES     = 12;
	localparam int STORE_IDX_W     = 4;
	localparam int BIT_COUNT_W     = 7;
	localparam int DEF_PACKET_BITS = 96;
	localparam int HEADER_MARKS    = 3;
	localparam int CLEAR_BYTE      = 6;
	localparam int COUNT_BYTE      = 7;

	// Request kind codes
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic carrier_on;
		logic busy_res;
		logic packet_done;
	} result_t;

	// Sequencer to packet store controls
	typedef struct packed {
		logic                   wr_en;
		logic [STORE_IDX_W-1:0] wr_idx;
		logic [7:0]             wr_val;
		logic                   finish;
	} store_ctl_t;

endpackage

`default_nettype wire

### sv/ipls_store.sv
// Twelve-byte packet store with one bit-select read port.
// On packet finish, clears the clear byte and increments the count byte.
// Depends on ipls_pkg.
`default_nettype none

module ipls_store import ipls_pkg::*; (
	input  wire logic                   clk,
	input  wire store_ctl_t             ctl,
	input  wire logic [BIT_COUNT_W-1:0] rd_pos,
	output logic                        rd_bit
);

	logic [7:0]             pkt_q [STORE_BYTES];
	logic [STORE_IDX_W-1:0] rd_byte;
	logic [7:0]             rd_data;

	// Byte writes, and the end-of-packet update
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			pkt_q[ctl.wr_idx] <= ctl.wr_val;
		end
		if (ctl.finish) begin
			pkt_q[CLEAR_BYTE] <= 8'h00;
			pkt_q[COUNT_BYTE] <= pkt_q[COUNT_BYTE] + 8'h01;
		end
	end

	// Bit select; bits past the store read as zero
	assign rd_byte = rd_pos[BIT_COUNT_W-1:3];

	always_comb begin
		if (rd_byte < STORE_IDX_W'(STORE_BYTES)) begin
			rd_data = pkt_q[rd_byte];
		end else begin
			rd_data = 8'h00;
		end
		rd_bit = rd_data[rd_pos[2:0]];
	end

endmodule

`default_nettype wire

### sv/ipls_seq.sv
// Slot sequencer: header, mark/space bit slots and packet end.
// Produces the result for each request and the packet store controls.
// Depends on ipls_pkg.
`default_nettype none

module ipls_seq import ipls_pkg::*; #(
	parameter int PACKET_BITS = DEF_PACKET_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   advance,
	input  wire item_t                  item,
	input  wire logic                   rd_bit,
	output logic [BIT_COUNT_W-1:0]      rd_pos,
	output store_ctl_t                  ctl,
	output result_t                     res,
	output logic                        sending,
	output logic                        in_header
);

	logic [BIT_COUNT_W-1:0] bit_count_q, bit_count_d;
	logic                   in_header_q, in_header_d;
	logic [1:0]             header_ticks_q, header_ticks_d;
	logic                   space_phase_q, space_phase_d;
	logic                   long_mark_q, long_mark_d;
	logic                   sending_q, sending_d;
	logic                   carrier_q, carrier_d;
	logic                   done;
	logic [BIT_COUNT_W:0]   next_count;

	assign rd_pos     = bit_count_q;
	assign next_count = {1'b0, bit_count_q} + {{BIT_COUNT_W{1'b0}}, 1'b1};

	// Next state for the request at the head of the input register
	always_comb begin
		bit_count_d    = bit_count_q;
		in_header_d    = in_header_q;
		header_ticks_d = header_ticks_q;
		space_phase_d  = space_phase_q;
		long_mark_d    = long_mark_q;
		sending_d      = sending_q;
		carrier_d      = carrier_q;
		done           = 1'b0;
		ctl.wr_en      = 1'b0;
		ctl.wr_idx     = item.byte_index;
		ctl.wr_val     = item.byte_value;
		ctl.finish     = 1'b0;
		case (item.kind)
			KIND_TICK: begin
				if (sending_q) begin
					if (in_header_q) begin
						if (header_ticks_q < 2'(HEADER_MARKS)) begin
							carrier_d      = 1'b1;
							header_ticks_d = header_ticks_q + 2'd1;
						end else begin
							carrier_d      = 1'b0;
							in_header_d    = 1'b0;
							header_ticks_d = 2'd0;
						end
					end else if (!space_phase_q) begin
						carrier_d = 1'b1;
						if (!long_mark_q) begin
							long_mark_d   = rd_bit;
							space_phase_d = !rd_bit;
						end else begin
							long_mark_d   = 1'b0;
							space_phase_d = 1'b1;
						end
					end else begin
						carrier_d     = 1'b0;
						long_mark_d   = 1'b0;
						space_phase_d = 1'b0;
						bit_count_d   = next_count[BIT_COUNT_W-1:0];
						if (next_count == (BIT_COUNT_W+1)'(PACKET_BITS)) begin
							ctl.finish     = 1'b1;
							sending_d      = 1'b0;
							in_header_d    = 1'b1;
							header_ticks_d = 2'd0;
							done           = 1'b1;
						end
					end
				end
			end
			KIND_WRITE: begin
				ctl.wr_en = !sending_q && (item.byte_index < STORE_IDX_W'(STORE_BYTES));
			end
			KIND_START: begin
				if (!sending_q) begin
					sending_d      = 1'b1;
					bit_count_d    = '0;
					in_header_d    = 1'b1;
					header_ticks_d = 2'd0;
					space_phase_d  = 1'b0;
					long_mark_d    = 1'b0;
				end
			end
			default: begin
				// unknown kind: state unchanged
			end
		endcase
		// store controls only act when the request really moves on
		ctl.wr_en  = ctl.wr_en && advance;
		ctl.finish = ctl.finish && advance;
		res.carrier_on  = carrier_d;
		res.busy_res    = sending_d;
		res.packet_done = done;
	end

	// Sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q    <= '0;
			in_header_q    <= 1'b1;
			header_ticks_q <= 2'd0;
			space_phase_q  <= 1'b0;
			long_mark_q    <= 1'b0;
			sending_q      <= 1'b0;
			carrier_q      <= 1'b0;
		end else if (advance) begin
			bit_count_q    <= bit_count_d;
			in_header_q    <= in_header_d;
			header_ticks_q <= header_ticks_d;
			space_phase_q  <= space_phase_d;
			long_mark_q    <= long_mark_d;
			sending_q      <= sending_d;
			carrier_q      <= carrier_d;
		end
	end

	assign sending   = sending_q;
	assign in_header = in_header_q;

endmodule

`default_nettype wire

### sv/ir_pulse_length_packet_sender.sv
// Top level of the IR pulse-length packet sender.
// Input register, slot sequencer, packet store and result register.
// Depends on ipls_pkg, ipls_store and ipls_seq.
//
//  Channel  | Signals                              | Payload
//  ---------+--------------------------------------+--------------------------------
//  request  | item_valid, item_ready, item         | kind, byte_index, byte_value
//  result   | result_valid, result_ready, result   | carrier_on, busy_res, packet_done
//
// One request per cycle while the result side does not stall; a request passes the input
// register, then the result register. The sequencer state steps once per request.
// Reset clears the handshake and sequencer state; the packet store is not cleared.
// A stalled result holds the result register; one more request may wait in the
// input register, and the request side stalls after that.
`default_nettype none

module ir_pulse_length_packet_sender import ipls_pkg::*; #(
	parameter int PACKET_BITS = DEF_PACKET_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	item_t                  item_s1;
	logic                   valid_s1;
	logic                   advance;
	result_t                res_d;
	result_t                result_q;
	logic                   result_valid_q;
	store_ctl_t             ctl;
	logic [BIT_COUNT_W-1:0] rd_pos;
	logic                   rd_bit;
	logic                   sending;
	logic                   in_header;

	// Request in the input register moves on when the result register is free
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	ipls_seq #(
		.PACKET_BITS(PACKET_BITS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.rd_bit   (rd_bit),
		.rd_pos   (rd_pos),
		.ctl      (ctl),
		.res      (res_d),
		.sending  (sending),
		.in_header(in_header)
	);

	ipls_store u_store (
		.clk   (clk),
		.ctl   (ctl),
		.rd_pos(rd_pos),
		.rd_bit(rd_bit)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.packet_done && (result.busy_res || result.carrier_on)))
		else $error("packet end reported while busy or carrier on");

	a_idle_header: assert property (@(posedge clk) disable iff (!arst_n)
		!sending |-> in_header)
		else $error("sequencer idle outside header state");

	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item_ready)
		else $error("request stalled with empty result register");

	a_store_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_en && ctl.finish) && (!ctl.finish || (advance && sending)))
		else $error("packet store write and finish clash");

endmodule

`default_nettype wire
